>>> hdl/bcdcal_pkg.sv
// Types, field codes and BCD helpers for the BCD calendar field bump block.
// No dependencies; used by bcdcal_bump and bcd_calendar_field_bump_top.
package bcdcal_pkg;

  localparam int unsigned NumFields = 6;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumFields-1:0] store_t;

  typedef enum logic [2:0] {
    FLD_MINUTE  = 3'd0,
    FLD_HOUR    = 3'd1,
    FLD_DATE    = 3'd2,
    FLD_MONTH   = 3'd3,
    FLD_WEEKDAY = 3'd4,
    FLD_YEAR    = 3'd5
  } field_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_BUMP = 1'b1
  } kind_e;

  localparam byte_t PmBit    = 8'h20;
  localparam byte_t H12Bit   = 8'h40;
  localparam byte_t MonFlag  = 8'h80;
  localparam byte_t HourMask = 8'h1f;
  localparam byte_t DateMask = 8'h3f;
  localparam byte_t StHrMask = 8'h3f;

  // Result of one item: store write enable, field code and the two output bytes.
  typedef struct packed {
    logic       we;
    logic [2:0] field;
    byte_t      written;
    byte_t      stored;
  } bump_res_t;

  // Face-value decode: 10*hi + lo, at most 165.
  function automatic byte_t from_bcd(input byte_t v);
    byte_t hi;
    hi = {4'd0, v[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
  endfunction

  // Binary to BCD, high digit truncated to a nibble. Divide by ten via
  // reciprocal multiply (exact for all 8-bit inputs).
  function automatic byte_t to_bcd(input byte_t v);
    logic [15:0] p;
    byte_t       q;
    byte_t       r;
    p = {8'd0, v} * 16'd205;
    q = {3'd0, p[15:11]};
    r = v - ((q << 3) + (q << 1));
    return {q[3:0], r[3:0]};
  endfunction

  // Days in month for months other than February; zero for February and for no month.
  function automatic byte_t month_days(input byte_t m);
    byte_t len;
    unique case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 8'd30;
      default:                                    len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/bcd_calendar_field_bump_top.sv
// BCD calendar field bump: six-field local time store with load/increment.
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while m_axis_tready_i is not holding the result;
// the store update is one short BCD compare and wrap between the input register
// and the result register.
// Reset (rst_ni low, async): all six time fields cleared to zero, both stages empty.
// Depends on bcdcal_pkg and bcdcal_bump.
module bcd_calendar_field_bump_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [2:0] field, [10:3] value, [15:11] zero
  input  logic        s_axis_tuser_i,  // [0] kind: 0 load, 1 increment
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [2:0] field_out, [10:3] written_byte,
                                       // [18:11] stored_byte, [23:19] zero
);

  // input stage
  logic                  in_vld_q, in_vld_d;
  logic                  in_kind_q;
  logic [2:0]            in_field_q;
  bcdcal_pkg::byte_t     in_value_q;

  // result stage
  logic                  out_vld_q, out_vld_d;
  logic [23:0]           out_data_q;

  // local time store
  bcdcal_pkg::store_t    store_q;

  bcdcal_pkg::bump_res_t res;
  logic                  in_xfer;
  logic                  advance;

  // Item leaves the input stage when the result register is free or draining.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end

    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Field logic reads the store as left by the previous item.
  bcdcal_bump u_bump (
    .kind_i  (in_kind_q),
    .field_i (in_field_q),
    .value_i (in_value_q),
    .store_i (store_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      store_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance && res.we) begin
        store_q[res.field] <= res.stored;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_kind_q  <= s_axis_tuser_i;
      in_field_q <= s_axis_tdata_i[2:0];
      in_value_q <= s_axis_tdata_i[10:3];
    end
    if (advance) begin
      out_data_q <= {5'd0, res.stored, res.written, res.field};
    end
  end

endmodule

>>> hdl/bcdcal_bump.sv
// Combinational load/increment of one BCD time field.
// Depends on bcdcal_pkg (store_t, field codes, BCD helpers).
module bcdcal_bump (
  input  logic                kind_i,
  input  logic [2:0]          field_i,
  input  bcdcal_pkg::byte_t   value_i,
  input  bcdcal_pkg::store_t  store_i,
  output bcdcal_pkg::bump_res_t res_o
);

  bcdcal_pkg::byte_t min_lo, min_hi;
  bcdcal_pkg::byte_t hr, hr_pm, hr_wr;
  bcdcal_pkg::byte_t yr_dec, mon_dec, day, day_len;
  logic              day_wrap;
  bcdcal_pkg::byte_t mon, wday, yr;
  bcdcal_pkg::byte_t wr, st;

  always_comb begin
    // minute: digit carry, tens wrap above 5
    min_lo = {4'd0, store_i[bcdcal_pkg::FLD_MINUTE][3:0]} + 8'd1;
    min_hi = {store_i[bcdcal_pkg::FLD_MINUTE][7:4], 4'd0};
    if (min_lo > 8'd9) begin
      min_lo = 8'd0;
      min_hi = min_hi + 8'h10;
      if (min_hi > 8'h50) begin
        min_hi = 8'd0;
      end
    end

    // hour: 12-hour count, PM flips on reaching 12
    hr    = bcdcal_pkg::from_bcd(store_i[bcdcal_pkg::FLD_HOUR] & bcdcal_pkg::HourMask)
            + 8'd1;
    hr_pm = store_i[bcdcal_pkg::FLD_HOUR] & bcdcal_pkg::PmBit;
    if (hr == 8'd12) begin
      hr_pm = hr_pm ^ bcdcal_pkg::PmBit;
    end
    if (hr > 8'd12) begin
      hr = 8'd1;
    end
    hr_wr = bcdcal_pkg::H12Bit | hr_pm | bcdcal_pkg::to_bcd(hr);

    // date: month length, leap February on year mod 4
    yr_dec  = bcdcal_pkg::from_bcd(store_i[bcdcal_pkg::FLD_YEAR]);
    mon_dec = bcdcal_pkg::from_bcd(store_i[bcdcal_pkg::FLD_MONTH] & bcdcal_pkg::HourMask);
    day     = bcdcal_pkg::from_bcd(store_i[bcdcal_pkg::FLD_DATE] & bcdcal_pkg::DateMask)
              + 8'd1;
    day_len = bcdcal_pkg::month_days(mon_dec);
    if (mon_dec == 8'd2) begin
      day_wrap = (yr_dec[1:0] != 2'd0) ? (day == 8'd29) : (day == 8'd30);
    end else if (mon_dec <= 8'd12) begin
      day_wrap = day > day_len;
    end else begin
      day_wrap = 1'b1;
    end
    if (day_wrap) begin
      day = 8'd1;
    end

    // month
    mon = mon_dec + 8'd1;
    if (mon > 8'd12) begin
      mon = 8'd1;
    end

    // weekday: raw count, wraps to 1 above 7; 0xff rolls to 0
    wday = store_i[bcdcal_pkg::FLD_WEEKDAY] + 8'd1;
    if (wday > 8'd7) begin
      wday = 8'd1;
    end

    // year
    yr = yr_dec + 8'd1;
    if (yr == 8'd100) begin
      yr = 8'd0;
    end

    wr = 8'd0;
    st = 8'd0;
    unique case (field_i)
      bcdcal_pkg::FLD_MINUTE: begin
        wr = min_hi | min_lo;
        st = wr;
      end
      bcdcal_pkg::FLD_HOUR: begin
        wr = hr_wr;
        st = hr_wr & bcdcal_pkg::StHrMask;
      end
      bcdcal_pkg::FLD_DATE: begin
        wr = bcdcal_pkg::to_bcd(day);
        st = wr;
      end
      bcdcal_pkg::FLD_MONTH: begin
        wr = bcdcal_pkg::to_bcd(mon) | bcdcal_pkg::MonFlag;
        st = wr;
      end
      bcdcal_pkg::FLD_WEEKDAY: begin
        wr = wday;
        st = wday;
      end
      bcdcal_pkg::FLD_YEAR: begin
        wr = bcdcal_pkg::to_bcd(yr);
        st = wr;
      end
      default: begin
        wr = 8'd0;
        st = 8'd0;
      end
    endcase

    res_o.field = field_i;
    res_o.we    = (field_i <= 3'(bcdcal_pkg::FLD_YEAR));
    if (!res_o.we) begin
      res_o.written = 8'd0;
      res_o.stored  = 8'd0;
    end else if (kind_i == bcdcal_pkg::KIND_LOAD) begin
      res_o.written = 8'd0;
      res_o.stored  = value_i;
    end else begin
      res_o.written = wr;
      res_o.stored  = st;
    end
  end

endmodule
